/* hw/rtl/fan_tach_period_speed_meter_defines.svh */
`ifndef FAN_TACH_PERIOD_SPEED_METER_DEFINES_SVH
`define FAN_TACH_PERIOD_SPEED_METER_DEFINES_SVH

// clocked on clk_i; FTSM_ASSERT is quiet while rst_ni is low, FTSM_ASSERT_ALWAYS is not
`ifndef NO_ASSERTIONS
`define FTSM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FTSM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define FTSM_ASSERT(name, prop, msg)
`define FTSM_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

/* hw/rtl/ftsm_pkg.sv */
`timescale 1ns / 1ps
package ftsm_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int FAN_COUNT   = 8;
  localparam int FAN_BITS    = 3;
  localparam int SPEED_BITS  = 16;
  localparam int FLAG_BITS   = 8;
  localparam int PRE_BITS    = 3;
  localparam int PS_BITS     = 2;

  localparam int RANGE_LIMIT = 18750;
  localparam int SPEED_SCALE = 30000000;
  localparam int SCALE_BITS  = $clog2(SPEED_SCALE + 1);
  localparam int ITER_BITS   = $clog2(SCALE_BITS);

  localparam logic [PS_BITS-1:0] PS_RESET = 2'd1;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef struct packed {
    logic beat;
    logic div_step;
    logic load_out;
  } ftsm_cmd_t;

  typedef struct packed {
    logic fin;
    logic div_last;
  } ftsm_sts_t;

endpackage

/* hw/rtl/ftsm_if.sv */
`timescale 1ns / 1ps
interface ftsm_in_if import ftsm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                action;
  logic [FAN_BITS-1:0] fan_index;
  logic                tach_level;

  modport source (output valid, action, fan_index, tach_level, input ready);
  modport sink   (input valid, action, fan_index, tach_level, output ready);
endinterface

interface ftsm_out_if import ftsm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FAN_BITS-1:0]   done_fan;
  logic [SPEED_BITS-1:0] speed;
  logic                  timed_out;
  logic [FLAG_BITS-1:0]  range_flags;

  modport source (output valid, done_fan, speed, timed_out, range_flags, input ready);
  modport sink   (input valid, done_fan, speed, timed_out, range_flags, output ready);
endinterface

interface ftsm_cfg_if import ftsm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PS_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* hw/rtl/ftsm_ctrl.sv */
`timescale 1ns / 1ps
module ftsm_ctrl import ftsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ftsm_sts_t sts_i,
  output ftsm_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_ACCEPT,
    S_DIV,
    S_OUT
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   div_step_q;
  logic   beat;

  assign beat = in_valid_i && in_ready_q;

  assign cmd_o.beat     = beat;
  assign cmd_o.div_step = div_step_q;
  assign cmd_o.load_out = div_step_q && sts_i.div_last;

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACCEPT;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
      div_step_q  <= 1'b0;
    end else begin
      case (state_q)
        S_ACCEPT: begin
          if (beat && sts_i.fin) begin
            state_q    <= S_DIV;
            in_ready_q <= 1'b0;
            div_step_q <= 1'b1;
          end
        end
        S_DIV: begin
          if (sts_i.div_last) begin
            state_q     <= S_OUT;
            div_step_q  <= 1'b0;
            out_valid_q <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            state_q     <= S_ACCEPT;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q     <= S_ACCEPT;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
          div_step_q  <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/ftsm_dp.sv */
`timescale 1ns / 1ps
module ftsm_dp import ftsm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ftsm_cmd_t             cmd_i,
  output ftsm_sts_t             sts_o,
  input  logic                  cfg_we_i,
  input  logic [PS_BITS-1:0]    cfg_data_i,
  input  logic                  action_i,
  input  logic [FAN_BITS-1:0]   fan_index_i,
  input  logic                  tach_level_i,
  output logic [FAN_BITS-1:0]   done_fan_o,
  output logic [SPEED_BITS-1:0] speed_o,
  output logic                  timed_out_o,
  output logic [FLAG_BITS-1:0]  range_flags_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_HIGH1,
    PH_WAIT_FALL1,
    PH_WAIT_HIGH2,
    PH_WAIT_FALL2
  } phase_e;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  phase_e                phase_q, phase_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [PRE_BITS-1:0]   pre_q, pre_d;
  logic [PRE_BITS-1:0]   pre_top;
  logic [FAN_BITS-1:0]   fan_q, fan_d;
  logic [FAN_COUNT-1:0]  range_q, range_d;
  logic [PS_BITS-1:0]    ps_q;
  logic                  fin;
  logic                  tmo;

  logic [COUNT_BITS-1:0] dvs_q;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [SCALE_BITS-1:0] quo_q, quo_d;
  logic [ITER_BITS-1:0]  iter_q;
  logic                  tmo_q;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   dvs_ext;
  logic                  ge;

  logic [FAN_BITS-1:0]   out_fan_q;
  logic [SPEED_BITS-1:0] out_speed_q, out_speed_d;
  logic                  out_tmo_q;
  logic [FLAG_BITS-1:0]  out_range_q, out_range_d;

  assign pre_top = PRE_BITS'((4'd1 << ps_q) - 4'd1);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    pre_d   = pre_q;
    fan_d   = fan_q;
    fin     = 1'b0;
    tmo     = 1'b0;
    if (cmd_i.beat) begin
      if (action_i == ACT_START) begin
        fan_d   = fan_index_i;
        cnt_d   = '0;
        pre_d   = '0;
        phase_d = PH_WAIT_HIGH1;
      end else if (phase_q != PH_IDLE) begin
        if (pre_q >= pre_top) begin
          pre_d = '0;
          if (cnt_q == CNT_MAX) begin
            cnt_d = '0;
            tmo   = 1'b1;
            fin   = 1'b1;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          pre_d = pre_q + 1'b1;
        end
        if (!tmo) begin
          case (phase_q)
            PH_WAIT_HIGH1: begin
              if (tach_level_i) phase_d = PH_WAIT_FALL1;
            end
            PH_WAIT_FALL1: begin
              if (!tach_level_i) begin
                cnt_d   = '0;
                pre_d   = '0;
                phase_d = PH_WAIT_HIGH2;
              end
            end
            PH_WAIT_HIGH2: begin
              if (tach_level_i) phase_d = PH_WAIT_FALL2;
            end
            PH_WAIT_FALL2: begin
              if (!tach_level_i) fin = 1'b1;
            end
            default: phase_d = PH_IDLE;
          endcase
        end
        if (fin) phase_d = PH_IDLE;
      end
    end
  end

  always_comb begin
    range_d = range_q;
    if (fin) begin
      for (int i = 0; i < FAN_COUNT; i++) begin
        if (fan_q == FAN_BITS'(i)) begin
          range_d[i] = !(tmo || (32'(cnt_d) > RANGE_LIMIT));
        end
      end
    end
  end

  // restoring divide of the fixed scale by the period; a zero period
  // yields all ones, which saturates to the top speed
  assign trial   = {rem_q, quo_q[SCALE_BITS-1]};
  assign dvs_ext = {1'b0, dvs_q};
  assign ge      = trial >= dvs_ext;
  assign rem_d   = ge ? COUNT_BITS'(trial - dvs_ext) : trial[COUNT_BITS-1:0];
  assign quo_d   = {quo_q[SCALE_BITS-2:0], ge};

  always_comb begin
    if (tmo_q) begin
      out_speed_d = '0;
    end else if (quo_d > SCALE_BITS'({SPEED_BITS{1'b1}})) begin
      out_speed_d = {SPEED_BITS{1'b1}};
    end else begin
      out_speed_d = quo_d[SPEED_BITS-1:0];
    end
    out_range_d = '0;
    for (int i = 0; i < FAN_COUNT; i++) begin
      out_range_d[i] = range_q[i];
    end
  end

  assign sts_o.fin      = fin;
  assign sts_o.div_last = iter_q == ITER_BITS'(SCALE_BITS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      pre_q   <= '0;
      fan_q   <= '0;
      range_q <= '0;
      ps_q    <= PS_RESET;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      pre_q   <= pre_d;
      fan_q   <= fan_d;
      range_q <= range_d;
      if (cfg_we_i) ps_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      dvs_q  <= cnt_d;
      rem_q  <= '0;
      quo_q  <= SCALE_BITS'(SPEED_SCALE);
      iter_q <= '0;
      tmo_q  <= tmo;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      iter_q <= iter_q + 1'b1;
    end
    if (cmd_i.load_out) begin
      out_fan_q   <= fan_q;
      out_speed_q <= out_speed_d;
      out_tmo_q   <= tmo_q;
      out_range_q <= out_range_d;
    end
  end

  assign done_fan_o    = out_fan_q;
  assign speed_o       = out_speed_q;
  assign timed_out_o   = out_tmo_q;
  assign range_flags_o = out_range_q;

endmodule

/* hw/rtl/fan_tach_period_speed_meter.sv */
// Channel  Dir  Beat                                      Fields
// cfg_i    in   prescale write                            data[1:0]
// in_i     in   start or tick                             action, fan_index, tach_level
// out_o    out  finished measurement                      done_fan, speed, timed_out,
//                                                         range_flags
// A start beat or a tick that ends nothing leaves in_i.ready high.
// A tick that ends a measurement starts the bit-serial divider, one
// quotient bit per cycle; then the result sits on out_o until taken.
// in_i.ready drops after the finishing tick and rises after the out_o beat; cfg_i.ready is always high.
// Reset clears phase, the period and prescale counters, fan and range bits at once; no sweep follows.
`timescale 1ns / 1ps
`include "fan_tach_period_speed_meter_defines.svh"
module fan_tach_period_speed_meter import ftsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ftsm_cfg_if.sink    cfg_i,
  ftsm_in_if.sink     in_i,
  ftsm_out_if.source  out_o
);

  ftsm_cmd_t cmd;
  ftsm_sts_t sts;

  assign cfg_i.ready = 1'b1;

  ftsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ftsm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .action_i      (in_i.action),
    .fan_index_i   (in_i.fan_index),
    .tach_level_i  (in_i.tach_level),
    .done_fan_o    (out_o.done_fan),
    .speed_o       (out_o.speed),
    .timed_out_o   (out_o.timed_out),
    .range_flags_o (out_o.range_flags)
  );

  `FTSM_ASSERT_ALWAYS(a_ready_excl_valid, !(in_i.ready && out_o.valid), "ready while result pending")
  `FTSM_ASSERT(a_fin_blocks, (cmd.beat && sts.fin) |=> !in_i.ready, "accepting during divide")
  `FTSM_ASSERT(a_out_after_div, $rose(out_o.valid) |-> $past(cmd.load_out), "result without divide")
  `FTSM_ASSERT(a_step_excl_out, !(cmd.div_step && out_o.valid), "divide step with result pending")

endmodule
